[hw/rtl/snappy_block_decompressor_unit_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the Snappy decompressor.
// Each macro checks a property under the clock and asynchronous reset.
// ----------------------------------------------------------------------------
`ifndef SNAPPY_BLOCK_DECOMPRESSOR_UNIT_MACROS_SVH
`define SNAPPY_BLOCK_DECOMPRESSOR_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Implication checked at every clock edge outside reset.
`define SBD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
// Next-cycle implication.
`define SBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define SBD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SBD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[hw/rtl/sbd_pkg.sv]
// ----------------------------------------------------------------------------
// sbd_pkg
// Types and constants shared by the Snappy decompressor modules.
// ----------------------------------------------------------------------------
package sbd_pkg;

	localparam int unsigned HistoryDepthDefault = 65536;

	// Status codes.
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_VARINT   = 3'd1;
	localparam logic [2:0] ST_TRUNC    = 3'd2;
	localparam logic [2:0] ST_OVERRUN  = 3'd3;
	localparam logic [2:0] ST_BADOFF   = 3'd4;
	localparam logic [2:0] ST_MISMATCH = 3'd5;
	localparam logic [2:0] ST_WINDOW   = 3'd6;

	// Command kinds from the parser to the executor.
	localparam logic [1:0] CMD_LIT  = 2'd0;
	localparam logic [1:0] CMD_COPY = 2'd1;
	localparam logic [1:0] CMD_END  = 2'd2;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_valid;
		logic       frame_done;
		logic [2:0] status;
	} out_item_t;

	// One command: a literal byte, a copy, or a bare end/error marker.
	// done and status apply to the last byte the command emits.
	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  lit;
		logic [31:0] off;
		logic [6:0]  len;
		logic        done;
		logic [2:0]  status;
	} cmd_t;

endpackage

[hw/rtl/sbd_parser.sv]
// ----------------------------------------------------------------------------
// sbd_parser
// Front end: accepts compressed bytes, parses the varint and tags, checks
// lengths and offsets, and issues literal, copy and end commands.
// ----------------------------------------------------------------------------
module sbd_parser #(
	parameter int unsigned HistoryDepth = sbd_pkg::HistoryDepthDefault
) (
	input  logic             clk,
	input  logic             arst_n,
	input  sbd_pkg::in_item_t in_item,
	input  logic             in_valid,
	output logic             in_ready,
	output sbd_pkg::cmd_t    cmd,
	output logic             cmd_valid,
	input  logic             cmd_ready
);

	localparam logic [2:0] PH_LEN = 3'd0;
	localparam logic [2:0] PH_TAG = 3'd1;
	localparam logic [2:0] PH_LITLEN = 3'd2;
	localparam logic [2:0] PH_LIT = 3'd3;
	localparam logic [2:0] PH_OFF = 3'd4;

	logic [2:0]  phase_q;
	logic [31:0] exp_q, prod_q, acc_q;
	logic [5:0]  shift_q;
	logic [7:0]  tag_q;
	logic [32:0] rem_q;
	logic        err_q;

	logic [7:0] b;
	logic       last, take;
	assign b = in_item.in_byte;
	assign last = in_item.in_last;
	assign in_ready = cmd_ready;
	assign take = in_valid && in_ready;

	// Next-state values computed for one accepted byte.
	logic [2:0]  phase_n;
	logic [31:0] exp_n, prod_n, acc_n, acc_or;
	logic [5:0]  shift_n;
	logic [7:0]  tag_n;
	logic [32:0] rem_n;
	logic [2:0]  err;
	logic        emit;
	sbd_pkg::cmd_t c;
	logic [32:0] lit_len, cp_len, cp_off;
	logic        do_lit, do_copy;
	logic [5:0]  need;

	always_comb begin
		phase_n = phase_q; exp_n = exp_q; prod_n = prod_q; acc_n = acc_q;
		shift_n = shift_q; tag_n = tag_q; rem_n = rem_q;
		err = sbd_pkg::ST_OK; emit = 1'b0;
		c = '0; c.kind = sbd_pkg::CMD_END;
		lit_len = '0; cp_len = '0; cp_off = '0; do_lit = 1'b0; do_copy = 1'b0;
		acc_or = acc_q | (32'(b) << shift_q);
		need = '0;
		unique case (phase_q)
			PH_LEN: begin
				if (shift_q >= 6'd28 && (b[7] || b[6:4] != 3'd0)) begin
					err = sbd_pkg::ST_VARINT;
				end else begin
					acc_n = acc_q | (32'(b[6:0]) << shift_q);
					if (!b[7]) begin
						exp_n = acc_n; acc_n = '0; shift_n = '0; phase_n = PH_TAG;
					end else begin
						shift_n = shift_q + 6'd7;
					end
				end
			end
			PH_TAG: begin
				tag_n = b; acc_n = '0; shift_n = '0;
				if (b[1:0] == 2'd0) begin
					if (b[7:2] < 6'd60) begin
						do_lit = 1'b1; lit_len = 33'(b[7:2]) + 33'd1;
					end else begin
						phase_n = PH_LITLEN;
					end
				end else begin
					phase_n = PH_OFF;
				end
			end
			PH_LITLEN: begin
				acc_n = acc_or; shift_n = shift_q + 6'd8;
				need = 6'({tag_q[7:2] - 6'd59, 3'd0});
				if (shift_n >= need) begin
					do_lit = 1'b1; lit_len = 33'(acc_or) + 33'd1;
				end
			end
			PH_LIT: begin
				emit = 1'b1; c.kind = sbd_pkg::CMD_LIT; c.lit = b;
				prod_n = prod_q + 32'd1; rem_n = rem_q - 33'd1;
				if (rem_n == '0) phase_n = PH_TAG;
			end
			default: begin
				if (tag_q[1:0] == 2'd1) begin
					do_copy = 1'b1;
					cp_off = {22'd0, tag_q[7:5], b};
					cp_len = 33'(tag_q[4:2]) + 33'd4;
				end else begin
					acc_n = acc_or; shift_n = shift_q + 6'd8;
					if (shift_n >= (tag_q[1:0] == 2'd2 ? 6'd16 : 6'd32)) begin
						do_copy = 1'b1; cp_off = 33'(acc_or);
						cp_len = 33'(tag_q[7:2]) + 33'd1;
					end
				end
			end
		endcase
		// Literal start: check against the expected length.
		if (do_lit) begin
			if (33'(prod_q) + lit_len > 33'(exp_q)) begin
				err = sbd_pkg::ST_OVERRUN;
			end else begin
				rem_n = lit_len; phase_n = PH_LIT;
			end
		end
		// Copy: offset and length checks, then one command.
		if (do_copy) begin
			if (cp_off == '0 || cp_off > 33'(prod_q)) err = sbd_pkg::ST_BADOFF;
			else if (cp_off > 33'(HistoryDepth)) err = sbd_pkg::ST_WINDOW;
			else if (33'(prod_q) + cp_len > 33'(exp_q)) err = sbd_pkg::ST_OVERRUN;
			else begin
				emit = 1'b1; c.kind = sbd_pkg::CMD_COPY;
				c.off = cp_off[31:0]; c.len = cp_len[6:0];
				prod_n = prod_q + 32'(cp_len); phase_n = PH_TAG;
			end
		end
		// Error or stream end closes the frame.
		if (err != sbd_pkg::ST_OK) begin
			emit = 1'b1; c = '0; c.kind = sbd_pkg::CMD_END;
			c.done = 1'b1; c.status = err;
		end else if (last) begin
			emit = 1'b1; c.done = 1'b1;
			if (phase_n == PH_TAG)
				c.status = (prod_n == exp_n) ? sbd_pkg::ST_OK : sbd_pkg::ST_MISMATCH;
			else
				c.status = sbd_pkg::ST_TRUNC;
		end
	end

	// Parser state update. After an error, bytes are dropped until the last one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEN; exp_q <= '0; prod_q <= '0; acc_q <= '0;
			shift_q <= '0; tag_q <= '0; rem_q <= '0; err_q <= 1'b0;
		end else if (take) begin
			if (err_q || last || err != sbd_pkg::ST_OK) begin
				phase_q <= PH_LEN; exp_q <= '0; prod_q <= '0; acc_q <= '0;
				shift_q <= '0; tag_q <= '0; rem_q <= '0;
				err_q <= !last && (err_q || (err != sbd_pkg::ST_OK));
			end else begin
				phase_q <= phase_n; exp_q <= exp_n; prod_q <= prod_n; acc_q <= acc_n;
				shift_q <= shift_n; tag_q <= tag_n; rem_q <= rem_n;
			end
		end
	end

	assign cmd = c;
	assign cmd_valid = take && !err_q && emit;

endmodule

[hw/rtl/sbd_cmd_fifo.sv]
// ----------------------------------------------------------------------------
// sbd_cmd_fifo
// Two-entry command queue between the parser and the copy engine.
// ----------------------------------------------------------------------------
module sbd_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  sbd_pkg::cmd_t wr_data,
	input  logic          wr_valid,
	output logic          wr_ready,
	output sbd_pkg::cmd_t rd_data,
	output logic          rd_valid,
	input  logic          rd_ready
);

	sbd_pkg::cmd_t mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       wr, rd;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign rd_data = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end

endmodule

[hw/rtl/sbd_copy_engine.sv]
// ----------------------------------------------------------------------------
// sbd_copy_engine
// Back end: writes literals into the history memory and expands copies one
// byte per cycle while the output slot is free, through a registered memory read.
// ----------------------------------------------------------------------------
module sbd_copy_engine #(
	parameter int unsigned HistoryDepth = sbd_pkg::HistoryDepthDefault
) (
	input  logic              clk,
	input  logic              arst_n,
	input  sbd_pkg::cmd_t     cmd,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	output sbd_pkg::out_item_t out_item,
	output logic              out_valid,
	input  logic              out_ready
);

	localparam int unsigned AW = (HistoryDepth > 1) ? $clog2(HistoryDepth) : 1;
	localparam logic [AW:0]   DEPTH = (AW+1)'(HistoryDepth);
	localparam logic [AW-1:0] LAST_ADDR = AW'(HistoryDepth - 1);

	logic [7:0] hist [HistoryDepth];

	// Write position: stream byte count modulo depth, kept across streams only
	// relative to the stream, so it restarts at each frame end.
	logic [AW-1:0] wpos_q;
	logic          busy_q;          // copy in progress
	logic [6:0]    left_q;          // copy bytes not yet requested
	logic [AW-1:0] src_q;
	logic          rdv_s1;          // memory read pending
	logic          rdlast_s1;
	logic          cdone_q;
	logic [2:0]    cstat_q;
	logic [7:0]    rdata_s1;

	sbd_pkg::out_item_t obuf_q;
	logic               ovld_q;
	logic               ofree;

	assign ofree = !ovld_q || out_ready;
	assign out_item = obuf_q;
	assign out_valid = ovld_q;

	// Forward a byte written while its address is being read to the read data.
	logic          fwd_q;
	logic [7:0]    fwd_byte_q;
	logic [7:0]    copy_byte;
	assign copy_byte = fwd_q ? fwd_byte_q : rdata_s1;

	// The engine advances only when the output slot is free.
	logic step;
	assign step = ofree;
	assign cmd_ready = step && !busy_q && !rdv_s1;

	// Copy source start and address increments, wrapping at the history depth.
	logic [AW-1:0] src_start;
	logic [AW:0]   off_mod;
	logic [AW:0]   src_full;
	logic [AW-1:0] wpos_inc;
	logic [AW-1:0] src_inc;
	always_comb begin
		off_mod = (AW+1)'(cmd.off);
		if (off_mod <= {1'b0, wpos_q})
			src_full = {1'b0, wpos_q} - off_mod;
		else
			src_full = {1'b0, wpos_q} + DEPTH - off_mod;
		src_start = src_full[AW-1:0];
		wpos_inc = (wpos_q == LAST_ADDR) ? '0 : wpos_q + AW'(1);
		src_inc = (src_q == LAST_ADDR) ? '0 : src_q + AW'(1);
	end

	logic          wen;
	logic [AW-1:0] waddr;
	logic [7:0]    wdata;
	logic          ren;
	logic [AW-1:0] raddr;

	always_comb begin
		wen = 1'b0; wdata = '0; waddr = wpos_q;
		ren = 1'b0; raddr = src_q;
		if (step && rdv_s1) begin
			wen = 1'b1; wdata = copy_byte;
		end else if (step && !busy_q && cmd_valid && cmd.kind == sbd_pkg::CMD_LIT) begin
			wen = 1'b1; wdata = cmd.lit;
		end
		if (step && busy_q) ren = 1'b1;
	end

	// History memory: one write and one registered read a cycle.
	always_ff @(posedge clk) begin
		if (wen) hist[waddr] <= wdata;
		if (ren) rdata_s1 <= hist[raddr];
	end

	// Forwarding register for a read of the address just written.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0; fwd_byte_q <= '0;
		end else if (step) begin
			fwd_q <= ren && wen && (raddr == waddr);
			fwd_byte_q <= wdata;
		end
	end

	// Next output transaction, frame end and write position.
	logic               out_load;
	logic               frame_end;
	logic               copy_start;
	sbd_pkg::out_item_t onext;
	logic [AW-1:0]      wpos_nx;
	always_comb begin
		out_load = 1'b0; frame_end = 1'b0; onext = obuf_q;
		copy_start = step && !busy_q && !rdv_s1 && cmd_valid &&
			cmd.kind == sbd_pkg::CMD_COPY;
		if (step && rdv_s1) begin
			out_load = 1'b1;
			onext.out_byte = copy_byte; onext.out_valid = 1'b1;
			onext.frame_done = rdlast_s1 && cdone_q;
			onext.status = (rdlast_s1 && cdone_q) ? cstat_q : sbd_pkg::ST_OK;
			frame_end = rdlast_s1 && cdone_q;
		end else if (step && !busy_q && cmd_valid && cmd.kind != sbd_pkg::CMD_COPY) begin
			out_load = 1'b1;
			onext.out_byte = (cmd.kind == sbd_pkg::CMD_LIT) ? cmd.lit : 8'd0;
			onext.out_valid = (cmd.kind == sbd_pkg::CMD_LIT);
			onext.frame_done = cmd.done; onext.status = cmd.status;
			frame_end = cmd.done;
		end
		if (frame_end) wpos_nx = '0;
		else if (wen) wpos_nx = wpos_inc;
		else wpos_nx = wpos_q;
	end

	// Output slot, read pipeline and copy control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wpos_q <= '0; busy_q <= 1'b0; left_q <= '0; src_q <= '0;
			rdv_s1 <= 1'b0; rdlast_s1 <= 1'b0; cdone_q <= 1'b0; cstat_q <= '0;
			ovld_q <= 1'b0; obuf_q <= '0;
		end else begin
			if (out_load) begin
				ovld_q <= 1'b1; obuf_q <= onext;
			end else if (out_ready) begin
				ovld_q <= 1'b0;
			end
			if (step) begin
				wpos_q <= wpos_nx;
				rdv_s1 <= ren;
				rdlast_s1 <= ren && (left_q == 7'd1);
			end
			if (copy_start) begin
				busy_q <= 1'b1; left_q <= cmd.len; src_q <= src_start;
				cdone_q <= cmd.done; cstat_q <= cmd.status;
			end else if (step && busy_q) begin
				src_q <= src_inc;
				left_q <= left_q - 7'd1;
				if (left_q == 7'd1) busy_q <= 1'b0;
			end
		end
	end

endmodule

[hw/rtl/snappy_block_decompressor_unit.sv]
// ----------------------------------------------------------------------------
// snappy_block_decompressor_unit
// Streaming raw Snappy decompressor with a parser front end, a command queue
// and a copy engine on a history memory.
//
//   Channel   Handshake              Payload
//   input     in_valid / in_ready    in_item  (in_byte, in_last)
//   output    out_valid / out_ready  out_item (out_byte, out_valid, ...)
//
// The parser takes one byte a cycle while the queue has room. A literal byte
// passes through the command queue and the output register before it is
// presented at the output. A copy occupies the engine until all its bytes are
// read, limited by the single registered read port of the history memory.
// Reset clears control state only; the history needs no clearing. Either side
// may stall at any time; the queue lets the parser keep going while a copy is expanded.
// ----------------------------------------------------------------------------
`include "snappy_block_decompressor_unit_macros.svh"
module snappy_block_decompressor_unit #(
	parameter int unsigned HistoryDepth = sbd_pkg::HistoryDepthDefault
) (
	input  logic               clk,
	input  logic               arst_n,
	input  sbd_pkg::in_item_t  in_item,
	input  logic               in_valid,
	output logic               in_ready,
	output sbd_pkg::out_item_t out_item,
	output logic               out_valid,
	input  logic               out_ready
);

	sbd_pkg::cmd_t p_cmd, q_cmd;
	logic p_valid, p_ready, q_valid, q_ready;

	sbd_parser #(.HistoryDepth(HistoryDepth)) u_parser (
		.clk(clk), .arst_n(arst_n), .in_item(in_item), .in_valid(in_valid),
		.in_ready(in_ready), .cmd(p_cmd), .cmd_valid(p_valid), .cmd_ready(p_ready)
	);

	sbd_cmd_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .wr_data(p_cmd), .wr_valid(p_valid),
		.wr_ready(p_ready), .rd_data(q_cmd), .rd_valid(q_valid), .rd_ready(q_ready)
	);

	sbd_copy_engine #(.HistoryDepth(HistoryDepth)) u_engine (
		.clk(clk), .arst_n(arst_n), .cmd(q_cmd), .cmd_valid(q_valid),
		.cmd_ready(q_ready), .out_item(out_item), .out_valid(out_valid),
		.out_ready(out_ready)
	);

	// A status is only reported on a frame-closing transaction.
	`SBD_ASSERT_IMP(a_status_done, clk, arst_n, out_valid && !out_item.frame_done, out_item.status == sbd_pkg::ST_OK)
	// A result without a byte always closes a frame.
	`SBD_ASSERT_IMP(a_empty_done, clk, arst_n, out_valid && !out_item.out_valid, out_item.frame_done)
	// A stalled result holds.
	`SBD_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_item))

endmodule

[bench/snappy_block_decompressor_unit_test.sv]
// ----------------------------------------------------------------------------
// Snappy block decompressor testbench
// Sends directed and random raw Snappy streams, both well-formed and broken,
// through the valid/ready input. A scoreboard predicts every output
// transaction and compares it field by field with what the block returns,
// under several patterns of sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module snappy_block_decompressor_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [2:0] {
		P_LEN, P_TAG, P_LITLEN, P_LIT, P_OFF
	} phase_t;

	// Predicts the decompressed bytes and holds them until they come back.
	class snappy_predictor;
		logic [7:0]  hist [65536];
		logic [31:0] exp_len;
		logic [31:0] produced;
		logic [5:0]  shift;
		phase_t      phase;
		logic [7:0]  tag;
		logic [31:0] acc;
		logic [63:0] remaining;
		bit          dropping;
		sbd_pkg::out_item_t pending [$];
		int          errors;

		function new();
			errors = 0;
			restart();
		endfunction

		function void restart();
			exp_len = 0;
			produced = 0;
			shift = 0;
			phase = P_LEN;
			tag = 0;
			acc = 0;
			remaining = 0;
			dropping = 0;
		endfunction

		function void emit(logic [7:0] b, ref sbd_pkg::out_item_t res [$]);
			hist[produced[15:0]] = b;
			produced++;
			res.insert(res.size(), sbd_pkg::out_item_t'{out_byte: b, out_valid: 1'b1,
				frame_done: 1'b0, status: sbd_pkg::ST_OK});
		endfunction

		function logic [2:0] start_lit(logic [63:0] n);
			if (64'(produced) + n > 64'(exp_len))
				return sbd_pkg::ST_OVERRUN;
			remaining = n;
			phase = P_LIT;
			return sbd_pkg::ST_OK;
		endfunction

		function logic [2:0] copy(logic [63:0] off, logic [63:0] n,
			ref sbd_pkg::out_item_t res [$]);
			logic [31:0] src;
			if (off == 0 || off > 64'(produced))
				return sbd_pkg::ST_BADOFF;
			if (off > 64'd65536)
				return sbd_pkg::ST_WINDOW;
			if (64'(produced) + n > 64'(exp_len))
				return sbd_pkg::ST_OVERRUN;
			for (int i = 0; i < n; i++) begin
				src = produced - off[31:0];
				emit(hist[src[15:0]], res);
			end
			phase = P_TAG;
			return sbd_pkg::ST_OK;
		endfunction

		// Works out the results of one accepted input transaction.
		function void note_input(sbd_pkg::in_item_t it);
			sbd_pkg::out_item_t res [$];
			logic [7:0] b;
			logic [2:0] err;
			logic [2:0] st;
			b = it.in_byte;
			err = sbd_pkg::ST_OK;
			if (dropping) begin
				if (it.in_last)
					restart();
				return;
			end
			case (phase)
				P_LEN: begin
					if (shift >= 28 && (b[7] || b[6:4] != 0)) begin
						err = sbd_pkg::ST_VARINT;
					end else begin
						acc |= 32'(b[6:0]) << shift;
						if (!b[7]) begin
							exp_len = acc;
							acc = 0;
							shift = 0;
							phase = P_TAG;
						end else begin
							shift += 7;
						end
					end
				end
				P_TAG: begin
					tag = b;
					acc = 0;
					shift = 0;
					if (b[1:0] == 2'd0) begin
						if (b[7:2] < 60)
							err = start_lit(64'(b[7:2]) + 1);
						else
							phase = P_LITLEN;
					end else begin
						phase = P_OFF;
					end
				end
				P_LITLEN: begin
					acc |= 32'(b) << shift;
					shift += 8;
					if (shift >= 8 * (tag[7:2] - 59))
						err = start_lit(64'(acc) + 1);
				end
				P_LIT: begin
					emit(b, res);
					remaining--;
					if (remaining == 0)
						phase = P_TAG;
				end
				default: begin
					if (tag[1:0] == 2'd1) begin
						err = copy({53'd0, tag[7:5], b}, 64'(tag[4:2]) + 4, res);
					end else begin
						acc |= 32'(b) << shift;
						shift += 8;
						if (shift >= (tag[1:0] == 2'd2 ? 16 : 32))
							err = copy(64'(acc), 64'(tag[7:2]) + 1, res);
					end
				end
			endcase
			if (err != sbd_pkg::ST_OK) begin
				pending.insert(pending.size(), sbd_pkg::out_item_t'{out_byte: 8'd0,
					out_valid: 1'b0, frame_done: 1'b1, status: err});
				if (it.in_last)
					restart();
				else
					dropping = 1;
				return;
			end
			if (it.in_last) begin
				if (phase == P_TAG)
					st = (produced == exp_len) ? sbd_pkg::ST_OK : sbd_pkg::ST_MISMATCH;
				else
					st = sbd_pkg::ST_TRUNC;
				if (res.size() > 0) begin
					res[$].frame_done = 1'b1;
					res[$].status = st;
				end else begin
					res.insert(res.size(), sbd_pkg::out_item_t'{out_byte: 8'd0,
						out_valid: 1'b0, frame_done: 1'b1, status: st});
				end
				restart();
			end
			foreach (res[i])
				pending.insert(pending.size(), res[i]);
		endfunction

		// Compares one output transaction with the oldest prediction.
		function void check_result(sbd_pkg::out_item_t got);
			sbd_pkg::out_item_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, got);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.out_byte !== want.out_byte || got.out_valid !== want.out_valid ||
				got.frame_done !== want.frame_done || got.status !== want.status) begin
				$display("%0t: mismatch, expected byte %h valid %b done %b status %0d,",
					$time, want.out_byte, want.out_valid, want.frame_done, want.status);
				$display("%0t:   actual byte %h valid %b done %b status %0d",
					$time, got.out_byte, got.out_valid, got.frame_done, got.status);
				errors++;
			end
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	sbd_pkg::in_item_t  in_item;
	logic      in_valid;
	logic      in_ready;
	sbd_pkg::out_item_t out_item;
	logic      out_valid;
	logic      out_ready;

	snappy_predictor model;
	int        in_idle;
	int        out_stall;
	int        quiet;
	logic [7:0] bytes_q [$];

	snappy_block_decompressor_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_item(in_item), .in_valid(in_valid), .in_ready(in_ready),
		.out_item(out_item), .out_valid(out_valid), .out_ready(out_ready)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// Output side: check accepted transactions and stall at random.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			model.check_result(out_item);
		out_ready <= ($urandom_range(99) < out_stall) ? 1'b0 : 1'b1;
	end

	// Watchdog on cycles without any accepted transaction.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet > 20000) begin
			$display("FAIL");
			$finish;
		end
	end

	// Sends one byte and waits until the transaction is accepted.
	task automatic send_byte(logic [7:0] b, logic last);
		if ($urandom_range(99) < in_idle) begin
			in_valid <= 1'b0;
			while ($urandom_range(99) < in_idle)
				@(posedge clk);
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= sbd_pkg::in_item_t'{in_byte: b, in_last: last};
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		model.note_input(sbd_pkg::in_item_t'{in_byte: b, in_last: last});
	endtask

	task automatic send_stream();
		foreach (bytes_q[i])
			send_byte(bytes_q[i], i == bytes_q.size() - 1);
	endtask

	// Appends one byte to the stream under construction.
	task automatic add_byte(logic [7:0] v);
		bytes_q.insert(bytes_q.size(), v);
	endtask

	task automatic put_varint(logic [31:0] v);
		logic [7:0] enc [$];
		do begin
			enc.insert(enc.size(), {v > 32'h7F, v[6:0]});
			v = v >> 7;
		end while (v != 0);
		for (int i = enc.size() - 1; i >= 0; i--)
			bytes_q.push_front(enc[i]);
	endtask

	// Builds a well-formed stream of random content, sometimes broken.
	task automatic build_random();
		int total, made, left, n, off, kind, pos;
		bytes_q.delete();
		if ($urandom_range(9) == 0) begin
			n = $urandom_range(1, 8);
			repeat (n) add_byte(8'($urandom));
			return;
		end
		total = $urandom_range(1, 24);
		made = 0;
		while (made < total) begin
			left = total - made;
			if (made == 0 || $urandom_range(1) == 0) begin
				n = $urandom_range(1, left);
				if (n <= 60 && $urandom_range(3) != 0) begin
					add_byte(8'((n - 1) << 2));
				end else if ($urandom_range(1) == 0) begin
					add_byte(8'(60 << 2));
					add_byte(8'(n - 1));
				end else begin
					add_byte(8'(61 << 2));
					add_byte(8'(n - 1));
					add_byte(8'd0);
				end
				repeat (n) add_byte(8'($urandom));
			end else begin
				off = $urandom_range(1, made);
				kind = $urandom_range(1, 3);
				if (kind == 1 && left >= 4) begin
					n = $urandom_range(4, left < 11 ? left : 11);
					add_byte({3'(off >> 8), 3'(n - 4), 2'd1});
					add_byte(8'(off));
				end else begin
					n = $urandom_range(1, left < 64 ? left : 64);
					add_byte({6'(n - 1), kind == 3 ? 2'd3 : 2'd2});
					add_byte(8'(off));
					add_byte(8'(off >> 8));
					if (kind == 3) begin
						add_byte(8'd0);
						add_byte(8'd0);
					end
				end
			end
			made += n;
		end
		// Occasionally break the stream: wrong length, corrupt or cut short.
		case ($urandom_range(9))
			0: total += $urandom_range(1) ? 1 : -1;
			1: bytes_q[$urandom_range(bytes_q.size() - 1)] = 8'($urandom);
			2: begin
				pos = $urandom_range(1, bytes_q.size());
				while (bytes_q.size() > pos)
					void'(bytes_q.pop_back());
			end
			default: ;
		endcase
		put_varint(total);
	endtask

	task automatic directed(input logic [7:0] seq [$]);
		bytes_q = seq;
		send_stream();
	endtask

	initial begin
		int sent;
		model = new();
		arst_n = 0;
		in_valid = 0;
		in_item = '0;
		out_ready = 0;
		in_idle = 0;
		out_stall = 0;
		quiet = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed streams: length extremes, every tag form, each error except the window error.
		directed('{8'h00});
		directed('{8'h00, 8'h00});
		directed('{8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h01});
		directed('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h1F});
		directed('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h0F, 8'h00, 8'hA5});
		directed('{8'h80});
		directed('{8'h05, 8'h10, 8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01});
		directed('{8'h04, 8'hF8, 8'h00, 8'h00, 8'h00});
		directed('{8'h04, 8'hFC, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
		directed('{8'h05, 8'hF0, 8'h01});
		directed('{8'h05, 8'h10, 8'hAA});
		directed('{8'h05, 8'h00, 8'h11, 8'h01, 8'h00, 8'h22});
		directed('{8'h05, 8'h00, 8'h11, 8'h01, 8'h05});
		directed('{8'h09, 8'h00, 8'h55, 8'h11, 8'h01});
		directed('{8'h09, 8'h00, 8'h55, 8'h11});
		directed('{8'h05, 8'h00, 8'hAA, 8'h0E, 8'h01, 8'h00});
		directed('{8'h05, 8'h00, 8'hAA, 8'h0F, 8'h01, 8'h00, 8'h00, 8'h00});
		directed('{8'h05, 8'h00, 8'hAA});
		directed('{8'h02, 8'h04, 8'h11, 8'h22, 8'h33});

		// Random streams under four idling patterns.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin in_idle = 0;  out_stall = 0;  end
				1: begin in_idle = 84; out_stall = 0;  end
				2: begin in_idle = 0;  out_stall = 84; end
				default: begin in_idle = 19; out_stall = 19; end
			endcase
			sent = 0;
			while (sent < 16) begin
				build_random();
				send_stream();
				sent += bytes_q.size();
			end
		end
		in_valid <= 1'b0;
		out_stall = 0;

		while (model.pending.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (model.errors == 0 && model.pending.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/sbd_pkg.sv
hw/rtl/sbd_parser.sv
hw/rtl/sbd_cmd_fifo.sv
hw/rtl/sbd_copy_engine.sv
hw/rtl/snappy_block_decompressor_unit.sv
bench/snappy_block_decompressor_unit_test.sv
